// ===== hdl/cowa_pkg.sv =====
// ----------------------------------------------------------------------------
// cowa_pkg
// shared types and constants for the channel occupancy window average block
// ----------------------------------------------------------------------------
package cowa_pkg;

	localparam int WINDOW_DEPTH = 256;
	localparam int PTR_W        = $clog2(WINDOW_DEPTH);
	localparam int FILL_W       = PTR_W + 1;
	localparam int ACC_W        = 40;
	localparam int TS_W         = 48;
	localparam int SUM_W        = 48;
	localparam int ISUM_W       = 56;
	localparam int DUR_W        = 32;

	localparam logic [8:0] LENGTH_RESET = 9'd200;
	localparam logic [1:0] PUSH_AFTER   = 2'd2;

	localparam logic [1:0] CMD_DURATION = 2'd0;
	localparam logic [1:0] CMD_BEACON   = 2'd1;
	localparam logic [1:0] CMD_CLEAR    = 2'd2;

	localparam logic [2:0] PHY_IDLE  = 3'd0;
	localparam logic [2:0] PHY_CCA   = 3'd1;
	localparam logic [2:0] PHY_TX    = 3'd2;
	localparam logic [2:0] PHY_RX    = 3'd3;
	localparam logic [2:0] PHY_SWT   = 3'd4;
	localparam logic [2:0] PHY_SLEEP = 3'd5;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [2:0]       phy_state;
		logic [DUR_W-1:0] duration_ns;
		logic [TS_W-1:0]  timestamp_ns;
	} in_item_t;

	typedef struct packed {
		logic [39:0] avg_idle_ns;
		logic [39:0] avg_busy_ns;
		logic [47:0] avg_interval_ns;
		logic [8:0]  window_fill;
		logic        bad_state;
		logic        averages_updated;
	} out_item_t;

	// control between sequencer and divider
	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

endpackage

// ===== hdl/cowa_ram.sv =====
// ----------------------------------------------------------------------------
// cowa_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module cowa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== hdl/cowa_div.sv =====
// ----------------------------------------------------------------------------
// cowa_div
// restoring divider, one quotient bit per cycle, 56-bit dividend
// ----------------------------------------------------------------------------
module cowa_div
	import cowa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ISUM_W-1:0] dividend,
	input  logic [FILL_W-1:0] divisor,
	output div_ctl_t          ctl,
	output logic [ISUM_W-1:0] quotient
);
	localparam int CNT_W = $clog2(ISUM_W + 1);

	logic [ISUM_W-1:0] quo_q;
	logic [FILL_W-1:0] rem_q;
	logic [FILL_W-1:0] dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [FILL_W:0]   trial;

	assign trial = {rem_q, quo_q[ISUM_W-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ISUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[FILL_W]) begin
				rem_q <= trial[FILL_W-1:0];
				quo_q <= {quo_q[ISUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[FILL_W-2:0], quo_q[ISUM_W-1]};
				quo_q <= {quo_q[ISUM_W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign quotient  = quo_q;
endmodule

// ===== hdl/channel_occupancy_window_average.sv =====
// ----------------------------------------------------------------------------
// channel_occupancy_window_average
// radio channel occupancy monitor with sliding-window averages
// ----------------------------------------------------------------------------
// duration transactions add to saturating idle/busy accumulators; beacon
// transactions, from the third one on, push idle, busy and interval samples
// into three windows (one ram each, WINDOW_DEPTH deep) and recompute the
// averages with one shared bit-serial divider. a duration, clear, ignored or
// non-pushing beacon transaction passes through accept, execute and done. a
// beacon that pushes passes through accept, execute, a drop check with one
// drop step per dropped oldest entry (one once the window is full, more after
// the window was shortened), push, the three divisions (start, one quotient
// step per dividend bit, capture) and done. no clearing pass: window entries
// are read only after being pushed, tracked by the fill count. one transaction
// is in work at a time and in_stall is high until it is done; the result then
// sits in an output register, so a waiting result holds up only the finish of
// the next transaction, not its acceptance.
module channel_occupancy_window_average
	import cowa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [8:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EXEC  = 7'b0000010,
		ST_DROPA = 7'b0000100,
		ST_DROPB = 7'b0001000,
		ST_PUSH  = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [8:0]        win_len_q;
	in_item_t          item_q;
	logic [ACC_W-1:0]  idle_acc_q, busy_acc_q;
	logic [TS_W-1:0]   last_ts_q, interval_q;
	logic [1:0]        seen_q;
	logic [PTR_W-1:0]  head_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  idle_sum_q, busy_sum_q;
	logic [ISUM_W-1:0] int_sum_q;
	logic [ACC_W-1:0]  avg_idle_q, avg_busy_q;
	logic [TS_W-1:0]   avg_int_q;
	logic [1:0]        div_sel_q;
	logic              bad_q, upd_q;
	logic              res_pending_q;
	out_item_t         out_q;

	// effective window length, clamped to 1..WINDOW_DEPTH
	logic [FILL_W-1:0] eff_len;
	always_comb begin
		if (win_len_q == '0) begin
			eff_len = FILL_W'(1);
		end else if (int'(win_len_q) > WINDOW_DEPTH) begin
			eff_len = FILL_W'(WINDOW_DEPTH);
		end else begin
			eff_len = FILL_W'(win_len_q);
		end
	end

	// ram address: head during push, oldest slot otherwise
	logic [PTR_W-1:0] ram_addr;
	logic             ram_we;
	logic [ACC_W-1:0] idle_rd, busy_rd;
	logic [TS_W-1:0]  int_rd;
	assign ram_addr = (state_q == ST_PUSH) ? head_q : (head_q - fill_q[PTR_W-1:0]);
	assign ram_we   = (state_q == ST_PUSH);

	cowa_ram #(.WIDTH(ACC_W), .DEPTH(WINDOW_DEPTH)) u_idle_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(idle_acc_q), .rdata(idle_rd));
	cowa_ram #(.WIDTH(ACC_W), .DEPTH(WINDOW_DEPTH)) u_busy_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(busy_acc_q), .rdata(busy_rd));
	cowa_ram #(.WIDTH(TS_W), .DEPTH(WINDOW_DEPTH)) u_int_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(interval_q), .rdata(int_rd));

	// shared divider over the three sums
	logic              div_start;
	logic [ISUM_W-1:0] div_dividend, div_quo;
	div_ctl_t          div_ctl;
	always_comb begin
		case (div_sel_q)
			2'd0:    div_dividend = ISUM_W'(idle_sum_q);
			2'd1:    div_dividend = ISUM_W'(busy_sum_q);
			default: div_dividend = int_sum_q;
		endcase
	end

	cowa_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(fill_q), .ctl(div_ctl), .quotient(div_quo));

	logic div_start_q;
	assign div_start = div_start_q;

	// saturating accumulate
	logic [ACC_W:0] acc_sum;
	logic           is_idle;
	assign is_idle = (item_q.phy_state == PHY_IDLE) || (item_q.phy_state == PHY_SLEEP);
	assign acc_sum = (is_idle ? {1'b0, idle_acc_q} : {1'b0, busy_acc_q})
		+ (ACC_W+1)'(item_q.duration_ns);

	logic [ACC_W-1:0] acc_sat;
	assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

	// input handshake: accept only in idle
	assign in_stall = (state_q != ST_IDLE);
	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// finished transaction moves to the output register once it is free
	logic done_go;
	assign done_go = (state_q == ST_DONE) && (!res_pending_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= LENGTH_RESET;
		end else if (cfg_we) begin
			win_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_pending_q <= 1'b0;
			out_q         <= '0;
		end else if (done_go) begin
			res_pending_q          <= 1'b1;
			out_q.avg_idle_ns      <= avg_idle_q;
			out_q.avg_busy_ns      <= avg_busy_q;
			out_q.avg_interval_ns  <= avg_int_q;
			out_q.window_fill      <= 9'(fill_q);
			out_q.bad_state        <= bad_q;
			out_q.averages_updated <= upd_q;
		end else if (!out_stall) begin
			res_pending_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idle_acc_q  <= '0;
			busy_acc_q  <= '0;
			last_ts_q   <= '0;
			interval_q  <= '0;
			seen_q      <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			idle_sum_q  <= '0;
			busy_sum_q  <= '0;
			int_sum_q   <= '0;
			avg_idle_q  <= '0;
			avg_busy_q  <= '0;
			avg_int_q   <= '0;
			div_sel_q   <= '0;
			div_start_q <= 1'b0;
			bad_q       <= 1'b0;
			upd_q       <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					bad_q   <= 1'b0;
					upd_q   <= 1'b0;
					state_q <= ST_DONE;
					case (item_q.cmd)
						CMD_DURATION: begin
							if (item_q.phy_state > PHY_SLEEP) begin
								bad_q <= 1'b1;
							end else if (is_idle) begin
								idle_acc_q <= acc_sat;
							end else begin
								busy_acc_q <= acc_sat;
							end
						end
						CMD_BEACON: begin
							interval_q <= item_q.timestamp_ns - last_ts_q;
							last_ts_q  <= item_q.timestamp_ns;
							if (seen_q >= PUSH_AFTER) begin
								upd_q   <= 1'b1;
								state_q <= ST_DROPA;
							end else begin
								seen_q     <= seen_q + 1'b1;
								idle_acc_q <= '0;
								busy_acc_q <= '0;
							end
						end
						CMD_CLEAR: begin
							idle_acc_q <= '0;
							busy_acc_q <= '0;
							last_ts_q  <= '0;
							seen_q     <= '0;
							head_q     <= '0;
							fill_q     <= '0;
							idle_sum_q <= '0;
							busy_sum_q <= '0;
							int_sum_q  <= '0;
							avg_idle_q <= '0;
							avg_busy_q <= '0;
							avg_int_q  <= '0;
						end
						default: ;
					endcase
				end
				// drop oldest while the window is full; read issued here
				ST_DROPA: begin
					if (fill_q >= eff_len && fill_q != '0) begin
						state_q <= ST_DROPB;
					end else begin
						state_q <= ST_PUSH;
					end
				end
				ST_DROPB: begin
					idle_sum_q <= idle_sum_q - SUM_W'(idle_rd);
					busy_sum_q <= busy_sum_q - SUM_W'(busy_rd);
					int_sum_q  <= int_sum_q - ISUM_W'(int_rd);
					fill_q     <= fill_q - 1'b1;
					state_q    <= ST_DROPA;
				end
				ST_PUSH: begin
					idle_sum_q  <= idle_sum_q + SUM_W'(idle_acc_q);
					busy_sum_q  <= busy_sum_q + SUM_W'(busy_acc_q);
					int_sum_q   <= int_sum_q + ISUM_W'(interval_q);
					head_q      <= head_q + 1'b1;
					fill_q      <= fill_q + 1'b1;
					idle_acc_q  <= '0;
					busy_acc_q  <= '0;
					div_sel_q   <= 2'd0;
					div_start_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_ctl.busy && !div_ctl.start) begin
						case (div_sel_q)
							2'd0: avg_idle_q <= div_quo[ACC_W-1:0];
							2'd1: avg_busy_q <= div_quo[ACC_W-1:0];
							default: avg_int_q <= div_quo[TS_W-1:0];
						endcase
						if (div_sel_q == 2'd2) begin
							state_q <= ST_DONE;
						end else begin
							div_sel_q   <= div_sel_q + 1'b1;
							div_start_q <= 1'b1;
						end
					end
				end
				// wait here while the output register still holds a stalled result
				ST_DONE: begin
					if (done_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = res_pending_q;
	assign out_data  = out_q;

	// fill never exceeds the window depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("fill above depth");

	// no input taken while a transaction is in work
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input accepted while busy");

	// divider only runs in the divide phase
	a_div_phase: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.busy |-> (state_q == ST_DIV))
		else $error("divider busy outside divide phase");

endmodule
